FILE: rtl/core/a1t_pkg.sv
// shared types and constants for the asn1 time to epoch parser
// no dependencies
package a1t_pkg;

  localparam int EpochW = 39;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FMT   = 2'd1,
    ST_RANGE = 2'd2,
    ST_LOCAL = 2'd3
  } status_t;

  localparam int SecsPerDay  = 86400;
  localparam int SecsPerYear = 31536000;
  localparam int EpochYear   = 1970;
  localparam int QueueDepth  = 2;

  // parsed fields of one complete string, handed from front to back
  typedef struct packed {
    logic [1:0]  err;
    logic        done;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        off_neg;
    logic [9:0]  off_min;
  } fields_t;

  // days before the first of a month, non-leap year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      4'd13:   d = 9'd365;
      4'd14:   d = 9'd365;
      4'd15:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/asn1_time_to_epoch_parser.sv
// top level: asn1 time string to epoch seconds
// depends on a1t_pkg, a1t_front, a1t_queue, a1t_back
//
// channel  direction  fields
// in       to block   char_code, time_kind, last   (in_valid / in_stall)
// out      from block epoch_seconds, status        (valid / stall)
//
// one character per cycle while in_stall is low
// the parser holds one string's fields until the queue takes them
// the converter is a three-stage pipeline, so strings go back to back
// rst is synchronous and clears all control state
module asn1_time_to_epoch_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic [1:0]  time_kind,
  input  logic        last,
  output logic        valid,
  input  logic        stall,
  output logic signed [38:0] epoch_seconds,
  output logic [1:0]  status
);
  import a1t_pkg::*;

  fields_t f_data, q_data;
  logic    f_valid, f_stall, q_valid, q_stall;

  a1t_front u_front (
    .clk, .rst, .char_code, .time_kind, .last, .in_valid, .in_stall,
    .f_valid, .f_stall, .f_data
  );

  a1t_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .w_valid(f_valid), .w_stall(f_stall), .w_data(f_data),
    .r_valid(q_valid), .r_stall(q_stall), .r_data(q_data)
  );

  a1t_back u_back (
    .clk, .rst, .q_valid, .q_stall, .q_data, .valid, .stall,
    .epoch_seconds, .status
  );
endmodule

FILE: rtl/core/a1t_front.sv
// character parser: checks field ranges, tracks the zone, emits parsed fields
// depends on a1t_pkg
module a1t_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       char_code,
  input  logic [1:0]       time_kind,
  input  logic             last,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             f_valid,
  input  logic             f_stall,
  output a1t_pkg::fields_t f_data
);
  import a1t_pkg::*;

  typedef enum logic [3:0] {
    PH_YEAR, PH_MON, PH_DAY, PH_HOUR, PH_MIN, PH_SECOPT, PH_SEC2,
    PH_POSTSEC, PH_OFFH, PH_OFFM, PH_END, PH_DONE
  } phase_t;

  phase_t      parse_phase, ph_n;
  logic [2:0]  digit_index, di_n;
  logic [13:0] field_accum, fa_n;
  logic [13:0] year_value, yr_n;
  logic [3:0]  month_value, mo_n;
  logic [4:0]  day_value, dy_n;
  logic [4:0]  hour_value, hr_n;
  logic [5:0]  minute_value, mi_n;
  logic [5:0]  second_value, se_n;
  logic        offset_negative, on_n;
  logic [9:0]  offset_minutes, om_n;
  logic [1:0]  error_code, er_n;
  logic        text_ended, te_n;
  logic        kind_general, kg_n;
  logic        started;

  logic        accept;
  assign in_stall = f_valid && f_stall;
  assign accept   = in_valid && !in_stall;

  // one character through the parser; combinational over one feed
  function automatic void feed(
    input  logic [7:0] c,
    inout  phase_t ph, inout logic [2:0] di, inout logic [13:0] fa,
    inout  logic [13:0] yr, inout logic [3:0] mo, inout logic [4:0] dy,
    inout  logic [4:0] hr, inout logic [5:0] mi, inout logic [5:0] se,
    inout  logic on, inout logic [9:0] om, inout logic [1:0] er,
    input  logic kg);
    logic        dig;
    logic [13:0] acc;
    logic [2:0]  cnt;
    logic [13:0] lo, hi;
    logic        ok;
    logic        post;
    dig  = c >= 8'h30 && c <= 8'h39;
    acc  = 14'(fa * 14'd10 + 14'(c - 8'h30));
    cnt  = 3'd2;
    lo   = 14'd0;
    hi   = 14'd99;
    ok   = 1'b0;
    post = 1'b0;
    if (er == 2'd0) begin
      unique case (ph)
        PH_YEAR:  begin cnt = kg ? 3'd4 : 3'd2; hi = kg ? 14'd9999 : 14'd99; end
        PH_MON:   begin lo = 14'd1; hi = 14'd12; end
        PH_DAY:   begin lo = 14'd1; hi = 14'd31; end
        PH_HOUR:  hi = 14'd23;
        PH_OFFH:  hi = 14'd12;
        default:  hi = 14'd59;
      endcase
      unique case (ph)
        PH_YEAR, PH_MON, PH_DAY, PH_HOUR, PH_MIN, PH_SEC2, PH_OFFH, PH_OFFM: begin
          if (!dig) er = ST_FMT;
          else begin
            di = di + 3'd1;
            if (di < cnt) fa = acc;
            else begin
              fa = '0;
              di = '0;
              if (acc < lo || acc > hi) er = ST_FMT;
              else ok = 1'b1;
            end
          end
          if (ok) begin
            unique case (ph)
              PH_YEAR: begin
                yr = kg ? acc : (acc < 14'd50 ? 14'd2000 + acc : 14'd1900 + acc);
                ph = PH_MON;
              end
              PH_MON:  begin mo = acc[3:0]; ph = PH_DAY; end
              PH_DAY:  begin dy = acc[4:0]; ph = PH_HOUR; end
              PH_HOUR: begin hr = acc[4:0]; ph = PH_MIN; end
              PH_MIN:  begin mi = acc[5:0]; ph = PH_SECOPT; end
              PH_SEC2: begin se = acc[5:0]; ph = PH_POSTSEC; end
              PH_OFFH: begin om = 10'(acc[3:0] * 6'd60); ph = PH_OFFM; end
              default: begin om = om + 10'(acc[5:0]); ph = PH_END; end
            endcase
          end
        end
        PH_SECOPT: begin
          if (dig) begin
            fa = 14'(c - 8'h30);
            di = 3'd1;
            ph = PH_SEC2;
          end else begin
            se = '0;
            ph = PH_POSTSEC;
            post = 1'b1;
          end
        end
        PH_POSTSEC: post = 1'b1;
        PH_END: begin
          if (c == 8'd0) ph = PH_DONE;
          else er = ST_FMT;
        end
        default: er = ST_FMT;
      endcase
      if (post) begin
        if (kg && (c == 8'h2e || c == 8'h2c || dig)) begin
        end else if (kg && c == 8'd0) er = ST_LOCAL;
        else if (c == 8'h5a) ph = PH_END;
        else if (c == 8'h2b || c == 8'h2d) begin
          on = (c == 8'h2d);
          ph = PH_OFFH;
        end else er = ST_FMT;
      end
    end
  endfunction

  always_comb begin
    ph_n = parse_phase; di_n = digit_index; fa_n = field_accum;
    yr_n = year_value; mo_n = month_value; dy_n = day_value;
    hr_n = hour_value; mi_n = minute_value; se_n = second_value;
    on_n = offset_negative; om_n = offset_minutes; er_n = error_code;
    te_n = text_ended; kg_n = kind_general;
    if (!started) begin
      if (time_kind == 2'd1) kg_n = 1'b1;
      else if (time_kind == 2'd0) kg_n = 1'b0;
      else er_n = ST_FMT;
    end
    // each character gets one feed; a string that ends without a zero byte gets a second feed below
    if (!text_ended) begin
      feed((last ? char_code : char_code), ph_n, di_n, fa_n, yr_n, mo_n, dy_n,
           hr_n, mi_n, se_n, on_n, om_n, er_n, kg_n);
      if (char_code == 8'd0) te_n = 1'b1;
    end
  end

  // a second feed of a zero byte when the string ends without one
  phase_t      ph2; logic [2:0] di2; logic [13:0] fa2, yr2; logic [3:0] mo2;
  logic [4:0]  dy2, hr2; logic [5:0] mi2, se2; logic on2; logic [9:0] om2;
  logic [1:0]  er2;
  always_comb begin
    ph2 = ph_n; di2 = di_n; fa2 = fa_n; yr2 = yr_n; mo2 = mo_n; dy2 = dy_n;
    hr2 = hr_n; mi2 = mi_n; se2 = se_n; on2 = on_n; om2 = om_n; er2 = er_n;
    if (!te_n)
      feed(8'd0, ph2, di2, fa2, yr2, mo2, dy2, hr2, mi2, se2, on2, om2, er2, kg_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_YEAR; digit_index <= '0; field_accum <= '0;
      year_value <= '0; month_value <= '0; day_value <= '0;
      hour_value <= '0; minute_value <= '0; second_value <= '0;
      offset_negative <= 1'b0; offset_minutes <= '0; error_code <= '0;
      text_ended <= 1'b0; kind_general <= 1'b0; started <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      // accept is blocked while a transfer waits, so a held one stays valid
      f_valid <= (accept && last) || (f_valid && f_stall);
      if (accept) begin
        if (last) begin
          parse_phase <= PH_YEAR; digit_index <= '0; field_accum <= '0;
          year_value <= '0; month_value <= '0; day_value <= '0;
          hour_value <= '0; minute_value <= '0; second_value <= '0;
          offset_negative <= 1'b0; offset_minutes <= '0; error_code <= '0;
          text_ended <= 1'b0; kind_general <= 1'b0; started <= 1'b0;
        end else begin
          parse_phase <= ph_n; digit_index <= di_n; field_accum <= fa_n;
          year_value <= yr_n; month_value <= mo_n; day_value <= dy_n;
          hour_value <= hr_n; minute_value <= mi_n; second_value <= se_n;
          offset_negative <= on_n; offset_minutes <= om_n; error_code <= er_n;
          text_ended <= te_n; kind_general <= kg_n; started <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      f_data.err     <= er2;
      f_data.done    <= (ph2 == PH_DONE);
      f_data.year    <= yr2;
      f_data.month   <= mo2;
      f_data.day     <= dy2;
      f_data.hour    <= hr2;
      f_data.minute  <= mi2;
      f_data.second  <= se2;
      f_data.off_neg <= on2;
      f_data.off_min <= om2;
    end
  end
endmodule

FILE: rtl/core/a1t_queue.sv
// short fifo of parsed strings between parser and converter
// depends on a1t_pkg
module a1t_queue #(
  parameter int Depth = a1t_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             w_valid,
  output logic             w_stall,
  input  a1t_pkg::fields_t w_data,
  output logic             r_valid,
  input  logic             r_stall,
  output a1t_pkg::fields_t r_data
);
  import a1t_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  fields_t        mem [Depth];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    cnt;
  logic           wr, rd;

  assign w_stall = (cnt == (AW+1)'(Depth));
  assign r_valid = (cnt != '0);
  assign wr      = w_valid && !w_stall;
  assign rd      = r_valid && !r_stall;
  assign r_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= w_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

FILE: rtl/core/a1t_back.sv
// converter: calendar fields to epoch seconds over three pipeline stages
// depends on a1t_pkg
module a1t_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_stall,
  input  a1t_pkg::fields_t q_data,
  output logic             valid,
  input  logic             stall,
  output logic signed [a1t_pkg::EpochW-1:0] epoch_seconds,
  output logic [1:0]       status
);
  import a1t_pkg::*;

  // stage 1: days and seconds-of-day
  logic        v1, v2;
  logic        adv1, adv2, adv3;
  logic [1:0]  st1, st2;
  logic        pre1, pre2;
  logic signed [22:0] days1;
  logic signed [18:0] sod1;

  logic        leap;
  logic [13:0] y;
  logic signed [15:0] ydiff;
  logic signed [22:0] days_c;
  logic signed [18:0] sod_c;
  logic [8:0]  db;
  logic [11:0] q4;
  logic [6:0]  cent;
  logic [4:0]  cent4;
  logic [13:0] ym1;
  logic [26:0] yq_p, mq_p;
  logic [6:0]  cent_y;
  logic [13:0] y100;

  assign adv3 = !(valid && stall);
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign q_stall = !adv1;

  always_comb begin
    y     = q_data.year;
    // divide by 100 through a reciprocal multiply, exact below 12800 as the quotient is 7 bits
    yq_p  = 27'(y) * 27'd5243;
    cent_y = 7'(yq_p >> 19);
    y100  = 14'(cent_y) * 14'd100;
    leap  = (y[1:0] == 2'b00) && ((y100 != y) || (cent_y[1:0] == 2'b00));
    ydiff = 16'(y) - 16'(EpochYear);
    db    = days_before(q_data.month);
    if (leap && q_data.month > 4'd2) db = db + 9'd1;
    // leap days between 1970 and the year: count of multiples of 4, less
    // centuries that are not multiples of 400, counted from year 0
    ym1   = (y == 14'd0) ? 14'd0 : y - 14'd1;
    q4    = 12'(ym1 >> 2);
    mq_p  = 27'(ym1) * 27'd5243;
    cent  = 7'(mq_p >> 19);
    cent4 = 5'(cent >> 2);
    days_c = 23'(ydiff) * 23'sd365 + 23'(q4) - 23'(cent) + 23'(cent4) + 23'(y != 0)
           - 23'sd478 + 23'(db) + 23'(q_data.day) - 23'sd1;
    sod_c = 19'(q_data.hour) * 19'sd3600 + 19'(q_data.second)
          + (19'(q_data.minute) - (q_data.off_neg ? -19'(q_data.off_min)
                                                  : 19'(q_data.off_min))) * 19'sd60;
  end

  logic signed [EpochW-1:0] r2;
  logic [1:0] st_c;
  logic signed [EpochW-1:0] r_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; valid <= 1'b0;
    end else begin
      if (adv1) v1 <= q_valid;
      if (adv2) v2 <= v1;
      if (adv3) valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && q_valid) begin
      days1 <= days_c;
      sod1  <= sod_c;
      pre1  <= (q_data.year < 14'(EpochYear));
      st1   <= (q_data.err != 2'd0) ? q_data.err : (q_data.done ? ST_OK : ST_FMT);
    end
    if (adv2 && v1) begin
      r2   <= EpochW'(days1) * EpochW'(SecsPerDay) + EpochW'(sod1);
      pre2 <= pre1;
      st2  <= st1;
    end
    if (adv3 && v2) begin
      epoch_seconds <= r_c;
      status        <= st_c;
    end
  end

  always_comb begin
    st_c = st2;
    if (st2 == ST_OK && (pre2 ? (r2 >= 0) : (r2 < 0))) st_c = ST_RANGE;
    r_c = (st_c == ST_OK) ? r2 : '0;
  end
endmodule

FILE: rtl/core/a1t_checker.sv
// port-level checks for the asn1 time parser
// depends on a1t_pkg; bound to asn1_time_to_epoch_parser
module a1t_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        valid,
  input logic        stall,
  input logic signed [38:0] epoch_seconds,
  input logic [1:0]  status
);
  import a1t_pkg::*;

  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    valid && status != ST_OK |-> epoch_seconds == '0) else $error("nonzero seconds");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && stall |=> valid && $stable(status) && $stable(epoch_seconds))
    else $error("result changed under stall");
  a_reset: assert property (@(posedge clk) rst |=> !valid) else $error("valid after reset");
  a_stall_known: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !$isunknown(in_stall)) else $error("input stall unknown");
endmodule

bind asn1_time_to_epoch_parser a1t_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .valid, .stall, .epoch_seconds, .status
);
